/* src/pwbs_pkg.sv */
package pwbs_pkg;

    localparam int WORD_W        = 24;
    localparam int FRAC_BITS_DEF = 12;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH     = 2;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int GRAVITY_W     = 16;
    localparam int REST_W        = 9;
    localparam int BOUND_W       = 11;
    localparam int SPLIT_W       = 16;

    localparam logic [GRAVITY_W-1:0] GRAVITY_RST = 16'd669;
    localparam logic [REST_W-1:0]    REST_RST    = 9'd218;
    localparam logic [BOUND_W-1:0]   RIGHT_RST   = 11'd640;
    localparam logic [BOUND_W-1:0]   BOTTOM_RST  = 11'd480;

    // 0.99 in Q0.16
    localparam logic [15:0] SHRINK_Q16 = 16'd64881;

    localparam logic signed [47:0] SAT_HI = 48'sd8388607;
    localparam logic signed [47:0] SAT_LO = -48'sd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY     = 2'd0,
        REG_RESTITUTION = 2'd1,
        REG_RIGHT       = 2'd2,
        REG_BOTTOM      = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        HIT_NONE   = 2'd0,
        HIT_LEFT   = 2'd1,
        HIT_RIGHT  = 2'd2,
        HIT_BOTTOM = 2'd3
    } hit_t;

    typedef logic [WORD_W-1:0] word_t;

    // vy holds the velocity with gravity already added
    typedef struct packed {
        word_t px;
        word_t py;
        word_t vx;
        word_t vy;
        word_t x1;
        word_t y1;
        hit_t  hit;
    } item_t;

    typedef struct packed {
        item_t item;
        word_t over;
        word_t den;
    } job_t;

    typedef struct packed {
        item_t item;
        word_t nvx;
        word_t nvy;
        word_t ad;
        logic  qi1;
        logic  qi2;
        logic  opp;
        logic  dzero;
    } carry_t;

    typedef struct packed {
        word_t new_x;
        word_t new_y;
        word_t new_vx;
        word_t new_vy;
        word_t prev_x;
        word_t prev_y;
        hit_t  wall_hit;
        logic  time_clamped;
    } res_t;

    function automatic word_t sat_word(input logic signed [47:0] v);
        word_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[WORD_W-1:0];
        end
        else if (v < SAT_LO) begin
            r = SAT_LO[WORD_W-1:0];
        end
        else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/pwbs_fifo.sv */
module pwbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* src/pwbs_front.sv */
module pwbs_front #(
    parameter int FRAC_BITS = pwbs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [pwbs_pkg::WORD_W-1:0]   pos_x,
    input  logic signed [pwbs_pkg::WORD_W-1:0]   pos_y,
    input  logic signed [pwbs_pkg::WORD_W-1:0]   vel_x,
    input  logic signed [pwbs_pkg::WORD_W-1:0]   vel_y,
    input  logic [pwbs_pkg::GRAVITY_W-1:0]       gravity,
    input  logic [pwbs_pkg::BOUND_W-1:0]         right_bound,
    input  logic [pwbs_pkg::BOUND_W-1:0]         bottom_bound,
    output logic                                 job_valid,
    output pwbs_pkg::job_t                       job,
    input  logic                                 job_full
);

    localparam int WW = pwbs_pkg::WORD_W;
    localparam int BW = pwbs_pkg::BOUND_W;
    localparam int CW = (FRAC_BITS + BW + 1 > WW + 1) ? FRAC_BITS + BW + 1 : WW + 1;

    logic adv;
    logic a_vld_reg, b_vld_reg;

    pwbs_pkg::word_t a_px_reg, a_py_reg, a_vx_reg, a_vy_reg, a_x1_reg;
    pwbs_pkg::word_t a_vy_next, a_x1_next;
    pwbs_pkg::job_t  b_job_reg, b_job_next;

    logic signed [WW+1:0]  vy_sum;
    logic signed [WW:0]    x_sum;
    logic signed [WW:0]    y_sum;
    pwbs_pkg::word_t       y1;
    logic signed [CW-1:0]  x1_w, y1_w, rb_w, bb_w, over_r, over_b;

    // hold both stages while stage B holds a job and the queue ahead is full
    assign adv       = !(b_vld_reg && job_full);
    assign full      = !adv;
    assign job_valid = b_vld_reg;
    assign job       = b_job_reg;

    assign vy_sum    = (WW+2)'(vel_y) + (WW+2)'($signed({1'b0, gravity}));
    assign x_sum     = (WW+1)'(pos_x) + (WW+1)'(vel_x);
    assign a_vy_next = pwbs_pkg::sat_word(48'(vy_sum));
    assign a_x1_next = pwbs_pkg::sat_word(48'(x_sum));

    assign y_sum  = (WW+1)'($signed(a_py_reg)) + (WW+1)'($signed(a_vy_reg));
    assign y1     = pwbs_pkg::sat_word(48'(y_sum));
    assign x1_w   = CW'($signed(a_x1_reg));
    assign y1_w   = CW'($signed(y1));
    assign rb_w   = CW'($signed({1'b0, right_bound, {FRAC_BITS{1'b0}}}));
    assign bb_w   = CW'($signed({1'b0, bottom_bound, {FRAC_BITS{1'b0}}}));
    assign over_r = x1_w - rb_w;
    assign over_b = y1_w - bb_w;

    always_comb
    begin
        b_job_next.item.px  = a_px_reg;
        b_job_next.item.py  = a_py_reg;
        b_job_next.item.vx  = a_vx_reg;
        b_job_next.item.vy  = a_vy_reg;
        b_job_next.item.x1  = a_x1_reg;
        b_job_next.item.y1  = y1;
        b_job_next.item.hit = pwbs_pkg::HIT_NONE;
        b_job_next.over     = '0;
        b_job_next.den      = '0;
        // left wall wins over right, right over the floor
        if (x1_w < 0)
        begin
            b_job_next.item.hit = pwbs_pkg::HIT_LEFT;
            b_job_next.over     = a_x1_reg;
            b_job_next.den      = a_vx_reg;
        end
        else if (x1_w > rb_w)
        begin
            b_job_next.item.hit = pwbs_pkg::HIT_RIGHT;
            b_job_next.over     = over_r[WW-1:0];
            b_job_next.den      = a_vx_reg;
        end
        else if (y1_w > bb_w)
        begin
            b_job_next.item.hit = pwbs_pkg::HIT_BOTTOM;
            b_job_next.over     = over_b[WW-1:0];
            b_job_next.den      = a_vy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= push;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
        begin
            a_px_reg <= pos_x;
            a_py_reg <= pos_y;
            a_vx_reg <= vel_x;
            a_vy_reg <= a_vy_next;
            a_x1_reg <= a_x1_next;
        end
        if (adv && a_vld_reg)
        begin
            b_job_reg <= b_job_next;
        end
    end

endmodule

/* src/pwbs_back.sv */
module pwbs_back #(
    parameter int FRAC_BITS = pwbs_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  pwbs_pkg::job_t                job,
    output logic                          job_pop,
    input  logic [pwbs_pkg::REST_W-1:0]   restitution,
    output logic                          res_valid,
    output pwbs_pkg::res_t                res,
    input  logic                          res_full
);

    localparam int WW  = pwbs_pkg::WORD_W;
    localparam int SW  = pwbs_pkg::SPLIT_W;
    localparam int PW  = WW + pwbs_pkg::REST_W + 1;
    localparam int MW  = WW + FRAC_BITS + 2;
    localparam int HW  = MW - SW + 17;
    localparam int AW  = HW + SW + 1;
    localparam int BVW = WW + 2;
    localparam int SMW = WW + 3;

    localparam logic [FRAC_BITS:0] ONE    = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);
    localparam logic [MW-1:0]      HALF_T = MW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [AW-1:0]      HALF_A = AW'(64'd1 << (FRAC_BITS + 15));

    logic en;

    // stage 1: magnitudes, signs, restitution product
    logic                 s1_vld_reg;
    pwbs_pkg::item_t      s1_item_reg;
    pwbs_pkg::word_t      s1_ao_reg, s1_ad_reg, s1_ao_next, s1_ad_next;
    logic                 s1_opp_reg, s1_dz_reg;
    logic signed [PW-1:0] s1_prod_reg, s1_prod_next;
    pwbs_pkg::word_t      vn;

    // stage 2 and divider chain, index 0 is the stage-2 output
    logic [FRAC_BITS:0]    dv_vld_reg;
    pwbs_pkg::word_t       rem_reg  [0:FRAC_BITS];
    pwbs_pkg::word_t       rem_next [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]  frac_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]  frac_next [0:FRAC_BITS];
    pwbs_pkg::carry_t      cr_reg  [0:FRAC_BITS];
    pwbs_pkg::carry_t      cr_next [0:FRAC_BITS];
    logic signed [PW:0]    refl_sum;
    logic signed [PW:0]    refl_shift;
    pwbs_pkg::word_t       refl;
    logic [WW:0]           dbl [1:FRAC_BITS];
    logic                  ge  [1:FRAC_BITS];

    // stage T: clamped fraction
    logic                 t_vld_reg;
    pwbs_pkg::carry_t     t_cr_reg;
    logic [FRAC_BITS:0]   t_reg, t_next, omt_reg;
    logic                 t_cl_reg, t_cl_next;

    // stage M1 to M4: placement
    logic                 m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg;
    pwbs_pkg::item_t      m1_item_reg, m2_item_reg, m3_item_reg;
    pwbs_pkg::word_t      m1_nvx_reg, m1_nvy_reg, m2_nvx_reg, m2_nvy_reg;
    pwbs_pkg::word_t      m3_nvx_reg, m3_nvy_reg;
    logic                 m1_cl_reg, m2_cl_reg, m3_cl_reg;
    logic signed [MW-1:0] m1_vx_reg, m1_vy_reg, m1_wx_reg, m1_wy_reg;
    logic signed [MW-1:0] m1_vx_next, m1_vy_next, m1_wx_next, m1_wy_next;
    logic signed [HW-1:0] m2_hix_reg, m2_hiy_reg, m2_hix_next, m2_hiy_next;
    logic [31:0]          m2_lox_reg, m2_loy_reg, m2_lox_next, m2_loy_next;
    logic signed [MW-1:0] wt_sum_x, wt_sum_y, wt_sh_x, wt_sh_y;
    logic signed [BVW-1:0] m2_bx_reg, m2_by_reg, m3_bx_reg, m3_by_reg;
    logic signed [AW-1:0] a_sum_x, a_sum_y, a_sh_x, a_sh_y;
    logic signed [BVW-1:0] m3_ax_reg, m3_ay_reg;
    logic signed [SMW-1:0] pos_sum_x, pos_sum_y;
    pwbs_pkg::res_t       m4_res_reg, m4_res_next;

    // the whole chain advances together; the result queue sets the pace
    assign en        = !res_full;
    assign job_pop   = en && job_valid;
    assign res_valid = m4_vld_reg;
    assign res       = m4_res_reg;

    // stage 1
    assign s1_ao_next   = job.over[WW-1] ? (~job.over + 1'b1) : job.over;
    assign s1_ad_next   = job.den[WW-1] ? (~job.den + 1'b1) : job.den;
    assign vn           = (job.item.hit == pwbs_pkg::HIT_BOTTOM) ? job.item.vy : job.item.vx;
    assign s1_prod_next = $signed(vn) * $signed({1'b0, restitution});

    // stage 2: reflected speed and integer part of the quotient
    assign refl_sum   = (PW+1)'(129'sd128) - (PW+1)'(s1_prod_reg);
    assign refl_shift = refl_sum >>> 8;
    assign refl       = pwbs_pkg::sat_word(48'(refl_shift));

    always_comb
    begin
        cr_next[0].item  = s1_item_reg;
        cr_next[0].nvx   = s1_item_reg.vx;
        cr_next[0].nvy   = s1_item_reg.vy;
        cr_next[0].ad    = s1_ad_reg;
        cr_next[0].qi1   = (s1_ao_reg >= s1_ad_reg);
        cr_next[0].qi2   = ({1'b0, s1_ao_reg} >= {s1_ad_reg, 1'b0});
        cr_next[0].opp   = s1_opp_reg;
        cr_next[0].dzero = s1_dz_reg;
        if (s1_item_reg.hit == pwbs_pkg::HIT_BOTTOM)
        begin
            cr_next[0].nvy = refl;
        end
        else if (s1_item_reg.hit != pwbs_pkg::HIT_NONE)
        begin
            cr_next[0].nvx = refl;
        end
        rem_next[0]  = cr_next[0].qi1 ? (s1_ao_reg - s1_ad_reg) : s1_ao_reg;
        frac_next[0] = '0;

        // one fraction bit per stage, restoring division
        for (int k = 1; k <= FRAC_BITS; k++)
        begin
            dbl[k]       = {rem_reg[k-1], 1'b0};
            ge[k]        = (dbl[k] >= {1'b0, cr_reg[k-1].ad});
            rem_next[k]  = ge[k] ? WW'(dbl[k] - {1'b0, cr_reg[k-1].ad}) : dbl[k][WW-1:0];
            frac_next[k] = {frac_reg[k-1][FRAC_BITS-2:0], ge[k]};
            cr_next[k]   = cr_reg[k-1];
        end
    end

    // stage T
    always_comb
    begin
        t_next    = '0;
        t_cl_next = 1'b0;
        if (cr_reg[FRAC_BITS].item.hit == pwbs_pkg::HIT_NONE)
        begin
            t_next = '0;
        end
        else if (cr_reg[FRAC_BITS].dzero)
        begin
            t_next    = ONE;
            t_cl_next = 1'b1;
        end
        else if (cr_reg[FRAC_BITS].opp)
        begin
            // a negative quotient that truncates to zero is not clamped
            t_cl_next = cr_reg[FRAC_BITS].qi1 || (frac_reg[FRAC_BITS] != '0);
        end
        else if (cr_reg[FRAC_BITS].qi2
                 || (cr_reg[FRAC_BITS].qi1 && (frac_reg[FRAC_BITS] != '0)))
        begin
            t_next    = ONE;
            t_cl_next = 1'b1;
        end
        else
        begin
            t_next = {cr_reg[FRAC_BITS].qi1, frac_reg[FRAC_BITS]};
        end
    end

    // stage M1
    assign m1_vx_next = $signed(t_cr_reg.item.vx) * $signed({1'b0, omt_reg});
    assign m1_vy_next = $signed(t_cr_reg.item.vy) * $signed({1'b0, omt_reg});
    assign m1_wx_next = $signed(t_cr_reg.nvx) * $signed({1'b0, t_reg});
    assign m1_wy_next = $signed(t_cr_reg.nvy) * $signed({1'b0, t_reg});

    // stage M2: split the damping product into two narrow multiplies
    assign m2_hix_next = $signed(m1_vx_reg[MW-1:SW]) * $signed({1'b0, pwbs_pkg::SHRINK_Q16});
    assign m2_hiy_next = $signed(m1_vy_reg[MW-1:SW]) * $signed({1'b0, pwbs_pkg::SHRINK_Q16});
    assign m2_lox_next = m1_vx_reg[SW-1:0] * pwbs_pkg::SHRINK_Q16;
    assign m2_loy_next = m1_vy_reg[SW-1:0] * pwbs_pkg::SHRINK_Q16;
    assign wt_sum_x    = m1_wx_reg + HALF_T;
    assign wt_sum_y    = m1_wy_reg + HALF_T;
    assign wt_sh_x     = wt_sum_x >>> FRAC_BITS;
    assign wt_sh_y     = wt_sum_y >>> FRAC_BITS;

    // stage M3
    assign a_sum_x = (AW'(m2_hix_reg) <<< SW) + AW'({1'b0, m2_lox_reg}) + HALF_A;
    assign a_sum_y = (AW'(m2_hiy_reg) <<< SW) + AW'({1'b0, m2_loy_reg}) + HALF_A;
    assign a_sh_x  = a_sum_x >>> (FRAC_BITS + 16);
    assign a_sh_y  = a_sum_y >>> (FRAC_BITS + 16);

    // stage M4
    assign pos_sum_x = SMW'($signed(m3_item_reg.px)) + SMW'(m3_ax_reg) + SMW'(m3_bx_reg);
    assign pos_sum_y = SMW'($signed(m3_item_reg.py)) + SMW'(m3_ay_reg) + SMW'(m3_by_reg);

    always_comb
    begin
        m4_res_next.prev_x       = m3_item_reg.px;
        m4_res_next.prev_y       = m3_item_reg.py;
        m4_res_next.new_vx       = m3_nvx_reg;
        m4_res_next.new_vy       = m3_nvy_reg;
        m4_res_next.wall_hit     = m3_item_reg.hit;
        m4_res_next.time_clamped = m3_cl_reg;
        if (m3_item_reg.hit == pwbs_pkg::HIT_NONE)
        begin
            m4_res_next.new_x = m3_item_reg.x1;
            m4_res_next.new_y = m3_item_reg.y1;
        end
        else
        begin
            m4_res_next.new_x = pwbs_pkg::sat_word(48'(pos_sum_x));
            m4_res_next.new_y = pwbs_pkg::sat_word(48'(pos_sum_y));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            t_vld_reg  <= 1'b0;
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= job_valid;
            dv_vld_reg <= {dv_vld_reg[FRAC_BITS-1:0], s1_vld_reg};
            t_vld_reg  <= dv_vld_reg[FRAC_BITS];
            m1_vld_reg <= t_vld_reg;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= job.item;
            s1_ao_reg   <= s1_ao_next;
            s1_ad_reg   <= s1_ad_next;
            s1_opp_reg  <= job.over[WW-1] ^ job.den[WW-1];
            s1_dz_reg   <= (job.den == '0);
            s1_prod_reg <= s1_prod_next;

            for (int k = 0; k <= FRAC_BITS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                frac_reg[k] <= frac_next[k];
                cr_reg[k]   <= cr_next[k];
            end

            t_cr_reg <= cr_reg[FRAC_BITS];
            t_reg    <= t_next;
            omt_reg  <= ONE - t_next;
            t_cl_reg <= t_cl_next;

            m1_item_reg <= t_cr_reg.item;
            m1_nvx_reg  <= t_cr_reg.nvx;
            m1_nvy_reg  <= t_cr_reg.nvy;
            m1_cl_reg   <= t_cl_reg;
            m1_vx_reg   <= m1_vx_next;
            m1_vy_reg   <= m1_vy_next;
            m1_wx_reg   <= m1_wx_next;
            m1_wy_reg   <= m1_wy_next;

            m2_item_reg <= m1_item_reg;
            m2_nvx_reg  <= m1_nvx_reg;
            m2_nvy_reg  <= m1_nvy_reg;
            m2_cl_reg   <= m1_cl_reg;
            m2_hix_reg  <= m2_hix_next;
            m2_hiy_reg  <= m2_hiy_next;
            m2_lox_reg  <= m2_lox_next;
            m2_loy_reg  <= m2_loy_next;
            m2_bx_reg   <= wt_sh_x[BVW-1:0];
            m2_by_reg   <= wt_sh_y[BVW-1:0];

            m3_item_reg <= m2_item_reg;
            m3_nvx_reg  <= m2_nvx_reg;
            m3_nvy_reg  <= m2_nvy_reg;
            m3_cl_reg   <= m2_cl_reg;
            m3_bx_reg   <= m2_bx_reg;
            m3_by_reg   <= m2_by_reg;
            m3_ax_reg   <= a_sh_x[BVW-1:0];
            m3_ay_reg   <= a_sh_y[BVW-1:0];

            m4_res_reg  <= m4_res_next;
        end
    end

endmodule

/* src/particle_wall_bounce_step_top.sv */
// Particle wall bounce, one frame per particle.
// Input side is a queue: drive pos_x, pos_y, vel_x, vel_y and raise push; the
// particle is taken on a rising edge with push high and full low.
// Result side is a queue too: while empty is low the oldest result sits on
// new_x .. time_clamped, and it is taken on a rising edge with pop high.
// Throughput is one particle per cycle while full stays low and results are popped.
// The back holds the divider for the remaining time fraction, which resolves
// one quotient bit per stage.
// A two-stage front adds gravity, moves and picks the wall; a short queue
// decouples it from the back, which divides, reflects and places back.
// When pop is held low the result queue fills, the back pipeline freezes,
// the middle queue fills and full rises; nothing is dropped.
// Reset empties every queue and pipeline and loads the register defaults.
// Registers are written through cfg_we/cfg_idx/cfg_wdata and
// must only change while no particle is in flight.
module particle_wall_bounce_step_top #(
    parameter int FRAC_BITS = pwbs_pkg::FRAC_BITS_DEF,
    parameter int MID_DEPTH = pwbs_pkg::MID_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [pwbs_pkg::WORD_W-1:0]  pos_x,
    input  logic signed [pwbs_pkg::WORD_W-1:0]  pos_y,
    input  logic signed [pwbs_pkg::WORD_W-1:0]  vel_x,
    input  logic signed [pwbs_pkg::WORD_W-1:0]  vel_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [pwbs_pkg::WORD_W-1:0]  new_x,
    output logic signed [pwbs_pkg::WORD_W-1:0]  new_y,
    output logic signed [pwbs_pkg::WORD_W-1:0]  new_vx,
    output logic signed [pwbs_pkg::WORD_W-1:0]  new_vy,
    output logic signed [pwbs_pkg::WORD_W-1:0]  prev_x,
    output logic signed [pwbs_pkg::WORD_W-1:0]  prev_y,
    output logic [1:0]                          wall_hit,
    output logic                                time_clamped,
    input  logic                                cfg_we,
    input  logic [pwbs_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [pwbs_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int JOB_W = $bits(pwbs_pkg::job_t);
    localparam int RES_W = $bits(pwbs_pkg::res_t);

    logic [pwbs_pkg::GRAVITY_W-1:0] gravity_reg;
    logic [pwbs_pkg::REST_W-1:0]    rest_reg;
    logic [pwbs_pkg::BOUND_W-1:0]   right_reg;
    logic [pwbs_pkg::BOUND_W-1:0]   bottom_reg;

    logic             f_job_valid;
    pwbs_pkg::job_t   f_job;
    logic             mid_full, mid_empty, mid_pop;
    logic [JOB_W-1:0] mid_rdata;
    pwbs_pkg::job_t   b_job;
    logic             b_res_valid;
    pwbs_pkg::res_t   b_res;
    logic             out_full;
    logic [RES_W-1:0] out_rdata;
    pwbs_pkg::res_t   out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= pwbs_pkg::GRAVITY_RST;
            rest_reg    <= pwbs_pkg::REST_RST;
            right_reg   <= pwbs_pkg::RIGHT_RST;
            bottom_reg  <= pwbs_pkg::BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                pwbs_pkg::REG_GRAVITY:
                begin
                    gravity_reg <= cfg_wdata[pwbs_pkg::GRAVITY_W-1:0];
                end
                pwbs_pkg::REG_RESTITUTION:
                begin
                    rest_reg <= cfg_wdata[pwbs_pkg::REST_W-1:0];
                end
                pwbs_pkg::REG_RIGHT:
                begin
                    right_reg <= cfg_wdata[pwbs_pkg::BOUND_W-1:0];
                end
                pwbs_pkg::REG_BOTTOM:
                begin
                    bottom_reg <= cfg_wdata[pwbs_pkg::BOUND_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    pwbs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .gravity      (gravity_reg),
        .right_bound  (right_reg),
        .bottom_bound (bottom_reg),
        .job_valid    (f_job_valid),
        .job          (f_job),
        .job_full     (mid_full)
    );

    pwbs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_job_valid),
        .wdata (f_job),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign b_job = mid_rdata;

    pwbs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!mid_empty),
        .job         (b_job),
        .job_pop     (mid_pop),
        .restitution (rest_reg),
        .res_valid   (b_res_valid),
        .res         (b_res),
        .res_full    (out_full)
    );

    pwbs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pwbs_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_res_valid),
        .wdata (b_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_res      = out_rdata;
    assign new_x        = out_res.new_x;
    assign new_y        = out_res.new_y;
    assign new_vx       = out_res.new_vx;
    assign new_vy       = out_res.new_vy;
    assign prev_x       = out_res.prev_x;
    assign prev_y       = out_res.prev_y;
    assign wall_hit     = out_res.wall_hit;
    assign time_clamped = out_res.time_clamped;

endmodule
